FILE: hw/rtl/tsyn_pkg.sv
// ----------------------------------------------------------------------------
// tsyn_pkg
// Shared types, constants and checksum helper for the TCP SYN packet builder.
// ----------------------------------------------------------------------------
package tsyn_pkg;

	// register map (index = paddr[3:2])
	localparam int unsigned ADDR_W = 4;
	localparam logic [1:0] REG_SOURCE_ADDRESS   = 2'd0;
	localparam logic [1:0] REG_TARGET_ADDRESS   = 2'd1;
	localparam logic [1:0] REG_BASE_SOURCE_PORT = 2'd2;
	localparam logic [1:0] REG_FIRST_PORT       = 2'd3;

	localparam logic [15:0] BASE_PORT_RESET  = 16'd40000;
	localparam logic [15:0] FIRST_PORT_RESET = 16'd1;

	// header fields
	localparam logic [15:0] VER_WORD    = 16'h4500;   // version 4, IHL 5
	localparam logic [15:0] TOTAL_LEN   = 16'd40;
	localparam logic [15:0] TTL_WORD    = 16'h4006;   // TTL 64, protocol TCP
	localparam logic [15:0] PROTO_TCP   = 16'd6;
	localparam logic [15:0] TCP_LEN     = 16'd20;
	localparam logic [15:0] SEQ_LOW     = 16'd1;
	localparam logic [15:0] OFF_WORD    = 16'h5002;   // data offset 5, SYN
	localparam logic [15:0] TCP_WINDOW  = 16'hFFFF;

	// constant parts of the two checksums
	localparam logic [19:0] IP_SUM_CONST  = 20'(VER_WORD) + 20'(TOTAL_LEN) + 20'(TTL_WORD);
	localparam logic [19:0] TCP_SUM_CONST = 20'(PROTO_TCP) + 20'(TCP_LEN) + 20'(SEQ_LOW)
	                                      + 20'(OFF_WORD) + 20'(TCP_WINDOW);

	localparam int unsigned WORDS_PER_PKT = 20;
	localparam logic [4:0]  LAST_POS      = 5'(WORDS_PER_PKT - 1);

	// front-to-back queue
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [15:0] sport;
		logic [15:0] dport;
		logic [15:0] ip_csum;
		logic [15:0] tcp_csum;
	} tsyn_desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tsyn_qstat_t;

	// end-around carry fold twice, then complement
	function automatic logic [15:0] fold_complement(input logic [19:0] sum);
		logic [16:0] f1;
		logic [16:0] f2;
		begin
			f1 = 17'(sum[19:16]) + 17'(sum[15:0]);
			f2 = 17'(f1[16]) + 17'(f1[15:0]);
			return ~f2[15:0];
		end
	endfunction

endpackage

FILE: hw/rtl/tsyn_front.sv
// ----------------------------------------------------------------------------
// tsyn_front
// Takes probe ports, derives the source port, computes both checksums and
// pushes a packet descriptor into the queue.
// ----------------------------------------------------------------------------
module tsyn_front import tsyn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] probe_port,
	input  logic [31:0] source_address,
	input  logic [31:0] target_address,
	input  logic [15:0] base_source_port,
	input  logic [15:0] first_port,
	input  tsyn_qstat_t qstat,
	output logic        push,
	output tsyn_desc_t  push_desc
);

	logic        valid_s1;
	logic [15:0] dport_s1;
	logic [15:0] sport_s1;
	logic [15:0] sport_c;
	logic [17:0] addr_sum;
	logic [19:0] ip_sum;
	logic [19:0] tcp_sum;
	logic        accept;

	assign in_stall = valid_s1 & qstat.full;
	assign accept   = in_valid & ~in_stall;
	assign sport_c  = base_source_port + (probe_port - first_port);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dport_s1 <= probe_port;
			sport_s1 <= sport_c;
		end
	end

	assign addr_sum = 18'(source_address[31:16]) + 18'(source_address[15:0])
	                + 18'(target_address[31:16]) + 18'(target_address[15:0]);
	assign ip_sum   = 20'(addr_sum) + IP_SUM_CONST;
	assign tcp_sum  = 20'(addr_sum) + TCP_SUM_CONST + 20'(sport_s1) + 20'(dport_s1);

	assign push               = valid_s1 & ~qstat.full;
	assign push_desc.sport    = sport_s1;
	assign push_desc.dport    = dport_s1;
	assign push_desc.ip_csum  = fold_complement(ip_sum);
	assign push_desc.tcp_csum = fold_complement(tcp_sum);

endmodule

FILE: hw/rtl/tsyn_queue.sv
// ----------------------------------------------------------------------------
// tsyn_queue
// Short descriptor queue between front and back.
// ----------------------------------------------------------------------------
module tsyn_queue import tsyn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  tsyn_desc_t  push_desc,
	input  logic        pop,
	output tsyn_desc_t  pop_desc,
	output tsyn_qstat_t qstat
);

	tsyn_desc_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_desc    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

FILE: hw/rtl/tsyn_back.sv
// ----------------------------------------------------------------------------
// tsyn_back
// Pops descriptors and serializes each packet as twenty 16-bit words into
// an output register.
// ----------------------------------------------------------------------------
module tsyn_back import tsyn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  tsyn_qstat_t qstat,
	input  tsyn_desc_t  pop_desc,
	output logic        pop,
	input  logic [31:0] source_address,
	input  logic [31:0] target_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] packet_word,
	output logic        last_word
);

	logic        active_q;
	logic [4:0]  pos_q;
	tsyn_desc_t  desc_q;
	logic        out_valid_q;
	logic [15:0] word_q;
	logic        last_q;
	logic        load;
	logic        finishing;
	logic [15:0] word_c;

	assign load      = ~out_valid_q | ~out_stall;
	assign finishing = active_q & load & (pos_q == LAST_POS);
	assign pop       = ~qstat.empty & (~active_q | finishing);

	always_comb begin
		case (pos_q)
			5'd0:    word_c = VER_WORD;
			5'd1:    word_c = TOTAL_LEN;
			5'd4:    word_c = TTL_WORD;
			5'd5:    word_c = desc_q.ip_csum;
			5'd6:    word_c = source_address[31:16];
			5'd7:    word_c = source_address[15:0];
			5'd8:    word_c = target_address[31:16];
			5'd9:    word_c = target_address[15:0];
			5'd10:   word_c = desc_q.sport;
			5'd11:   word_c = desc_q.dport;
			5'd13:   word_c = SEQ_LOW;
			5'd16:   word_c = OFF_WORD;
			5'd17:   word_c = TCP_WINDOW;
			5'd18:   word_c = desc_q.tcp_csum;
			default: word_c = 16'h0000;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= active_q;
			end
			if (pop) begin
				active_q <= 1'b1;
				pos_q    <= '0;
			end else if (active_q && load) begin
				pos_q <= pos_q + 1'b1;
				if (pos_q == LAST_POS) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= pop_desc;
		end
		if (load) begin
			word_q <= word_c;
			last_q <= (pos_q == LAST_POS);
		end
	end

	assign out_valid   = out_valid_q;
	assign packet_word = word_q;
	assign last_word   = last_q;

endmodule

FILE: hw/rtl/tcp_syn_packet_builder_top.sv
// ----------------------------------------------------------------------------
// tcp_syn_packet_builder_top
// Builds 40-byte IPv4 + TCP SYN probes, one per destination port.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / probe_port): one transfer per probe,
//   carrying the TCP destination port.
//   Output channel (out_valid / out_stall / packet_word / last_word): twenty
//   transfers per probe, 16-bit words in network byte order; last_word marks
//   the twentieth.
//   APB port: source_address (0x0), target_address (0x4), base_source_port
//   (0x8), first_port (0xC). Write only while no probe is in flight.
// Path: the first word of a packet passes the front stage register, the
//   queue, the back-end descriptor register and the output register.
// Throughput: one word per cycle while out_stall is low; the serializer in
//   the back end sets that rate. Words of consecutive packets follow without
//   gaps when the next descriptor is already queued.
// Input is accepted back to back until the front stage and the two-entry
//   descriptor queue are full; then in_stall rises.
// Output stall: the output register holds its word and the serializer waits.
// Reset: clears all control state, addresses to zero, base_source_port to
//   40000, first_port to 1; no probe is pending afterward.
// ----------------------------------------------------------------------------
module tcp_syn_packet_builder_top import tsyn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [15:0]       probe_port,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [15:0]       packet_word,
	output logic              last_word
);

	logic [31:0] source_address_q;
	logic [31:0] target_address_q;
	logic [15:0] base_source_port_q;
	logic [15:0] first_port_q;
	logic        cfg_wr;
	logic [1:0]  reg_idx;

	logic        push;
	logic        pop;
	tsyn_desc_t  push_desc;
	tsyn_desc_t  pop_desc;
	tsyn_qstat_t qstat;

	// register file: zero-wait APB, word-aligned decode
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_address_q   <= '0;
			target_address_q   <= '0;
			base_source_port_q <= BASE_PORT_RESET;
			first_port_q       <= FIRST_PORT_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_SOURCE_ADDRESS:   source_address_q   <= pwdata;
				REG_TARGET_ADDRESS:   target_address_q   <= pwdata;
				REG_BASE_SOURCE_PORT: base_source_port_q <= pwdata[15:0];
				REG_FIRST_PORT:       first_port_q       <= pwdata[15:0];
				default:              ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SOURCE_ADDRESS:   prdata = source_address_q;
			REG_TARGET_ADDRESS:   prdata = target_address_q;
			REG_BASE_SOURCE_PORT: prdata = {16'h0000, base_source_port_q};
			REG_FIRST_PORT:       prdata = {16'h0000, first_port_q};
			default:              prdata = '0;
		endcase
	end

	// front: port math and checksums
	tsyn_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.probe_port       (probe_port),
		.source_address   (source_address_q),
		.target_address   (target_address_q),
		.base_source_port (base_source_port_q),
		.first_port       (first_port_q),
		.qstat            (qstat),
		.push             (push),
		.push_desc        (push_desc)
	);

	// descriptor queue
	tsyn_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.pop_desc  (pop_desc),
		.qstat     (qstat)
	);

	// back: word serializer
	tsyn_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.qstat          (qstat),
		.pop_desc       (pop_desc),
		.pop            (pop),
		.source_address (source_address_q),
		.target_address (target_address_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.packet_word    (packet_word),
		.last_word      (last_word)
	);

	// within a packet, words come without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_word |=> out_valid)
		else $error("gap inside a packet");

	// every packet opens with the version/IHL word
	a_pkt_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_word |=> !out_valid || packet_word == VER_WORD)
		else $error("packet does not start with version word");

	// queue is never written while full nor read while empty
	a_queue_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full) && !(pop && qstat.empty))
		else $error("descriptor queue overflow or underflow");

endmodule
